// ===== hdl/tws_pkg.sv =====
// shared types, sizes and codes for the time window spike fifo
`default_nettype none

package tws_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 6;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W   = CMP_W + 1;
    localparam int STAMP_W = 32;
    localparam int CONN_W  = 16;
    localparam int ENTRY_W = STAMP_W + CONN_W;
    localparam int WIN_W   = 31;
    localparam int SPIKE_COUNT_W = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_WINDOW = 1'b0;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        command;
        logic [CONN_W-1:0] connection_id;
        logic [15:0]       elapsed_ticks;
        logic [POS_W-1:0]  position;
    } t_in_word;

    typedef struct packed {
        logic [SPIKE_COUNT_W-1:0] spike_count;
        logic                     entry_valid;
        logic [STAMP_W-1:0]       entry_age;
        logic [CONN_W-1:0]        entry_connection;
        logic                     add_dropped;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hdl/time_window_spike_fifo.sv =====
// time window spike fifo: top level with sequencer, pointers and apb window register
// add and unused: idle then done; read: idle, rd_wait, done (one registered ram read)
// advance: adv_rd and adv_chk for each head checked, to done on a live head or empty fifo
// every pop is a ram read of the head stamp then one shared age subtract and compare
// one word in flight at a time; the next is taken while the last result waits at the output
// sync active-low reset clears pointers, count, time and window; ram contents stay undefined
`default_nettype none

module time_window_spike_fifo
    import tws_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_data,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // sequencer and pointer state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [STAMP_W-1:0] r_time, n_time;
    logic [WIN_W-1:0]   r_window;

    // partial result of the word in flight
    logic               r_hit, n_hit;
    logic               r_dropped, n_dropped;
    logic [STAMP_W-1:0] r_age, n_age;
    logic [CONN_W-1:0]  r_conn, n_conn;

    // output register
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    // ram side
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic [ENTRY_W-1:0] w_rd_data;
    logic [STAMP_W-1:0] w_rd_stamp;
    logic [CONN_W-1:0]  w_rd_conn;

    logic               w_accept;
    logic               w_full;
    logic [IDX_W-1:0]   w_head_inc;
    logic [IDX_W-1:0]   w_tail_inc;
    logic [SUM_W-1:0]   w_pos_sum;
    logic [IDX_W-1:0]   w_pos_addr;
    logic               w_pos_hit;
    logic [STAMP_W-1:0] w_age;
    logic               w_expired;
    logic [SUM_W-1:0]   w_ptr_sum;
    logic [IDX_W-1:0]   w_ptr_wrap;
    logic               w_cfg_wr;

    // stamp and connection id share one ram word
    tws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data ({r_time, i_in_data.connection_id}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_stamp = w_rd_data[ENTRY_W-1:CONN_W];
    assign w_rd_conn  = w_rd_data[CONN_W-1:0];

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_inc = (r_tail == IDX_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // read position counted from the head, wrapped once; only used when it hits
    assign w_pos_sum  = SUM_W'(r_head) + SUM_W'(i_in_data.position);
    assign w_pos_addr = (w_pos_sum >= SUM_W'(DEPTH)) ? IDX_W'(w_pos_sum - SUM_W'(DEPTH))
                                                     : IDX_W'(w_pos_sum);
    assign w_pos_hit  = (CMP_W'(i_in_data.position) < CMP_W'(r_count));

    // the one shared age unit: current time minus stored stamp, mod 2^32
    assign w_age      = r_time - w_rd_stamp;
    assign w_expired  = (w_age > {1'b0, r_window});

    // ram read address: read position while taking a word, head otherwise
    assign w_rd_addr  = (r_state == ST_IDLE) ? w_pos_addr : r_head;

    // head plus count wrapped must always land on the tail
    assign w_ptr_sum  = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_ptr_wrap = (w_ptr_sum >= SUM_W'(DEPTH)) ? IDX_W'(w_ptr_sum - SUM_W'(DEPTH))
                                                     : IDX_W'(w_ptr_sum);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // apb window register, zero wait state
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW);
    assign prdata   = (paddr[2:2] == REG_WINDOW) ? APB_DATA_W'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (w_cfg_wr) begin
            r_window <= pwdata[WIN_W-1:0];
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_hit     <= n_hit;
        r_dropped <= n_dropped;
        r_age     <= n_age;
        r_conn    <= n_conn;
        r_out     <= n_out;
    end

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_time      = r_time;
        n_hit       = r_hit;
        n_dropped   = r_dropped;
        n_age       = r_age;
        n_conn      = r_conn;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_hit     = 1'b0;
                    n_dropped = 1'b0;
                    n_age     = '0;
                    n_conn    = '0;
                    unique case (i_in_data.command)
                        CMD_ADD: begin
                            // full fifo refuses the spike and leaves state alone
                            if (w_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                w_wr_en = 1'b1;
                                n_tail  = w_tail_inc;
                                n_count = r_count + 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        CMD_ADVANCE: begin
                            n_time  = r_time + STAMP_W'(i_in_data.elapsed_ticks);
                            n_state = ST_ADV_RD;
                        end
                        CMD_READ: begin
                            // ram read of the position is issued this cycle
                            n_hit   = w_pos_hit;
                            n_state = ST_RD_WAIT;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                if (r_hit) begin
                    n_age  = w_age;
                    n_conn = w_rd_conn;
                end
                n_state = ST_DONE;
            end
            ST_ADV_RD: begin
                // head stamp read is issued here
                n_state = (r_count == '0) ? ST_DONE : ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                if (w_expired) begin
                    n_head  = w_head_inc;
                    n_count = r_count - 1'b1;
                    n_state = ST_ADV_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid            = 1'b1;
                    n_out.spike_count      = SPIKE_COUNT_W'(r_count);
                    n_out.entry_valid      = r_hit;
                    n_out.entry_age        = r_age;
                    n_out.entry_connection = r_conn;
                    n_out.add_dropped      = r_dropped;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // fill count never goes past the ram depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // pointers and fill count stay consistent
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ptr_wrap == r_tail)
        else $error("head plus count does not match tail");

    // an expired head is popped on the next edge
    a_pop_on_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADV_CHK && w_expired) |=> r_count == $past(r_count) - 1'b1)
        else $error("expired head not popped");

    // a refused add only happens with the fifo full
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.add_dropped) |->
            o_out_data.spike_count == SPIKE_COUNT_W'(DEPTH))
        else $error("add dropped while fifo not full");

endmodule

`default_nettype wire

// ===== hdl/tws_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module tws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the time window spike fifo: directed and random words against a local predictor
`timescale 1ns / 1ps

module tb_top;
    import tws_pkg::*;

    // cycles with no word moving on either channel before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // window register sits at byte offset 4 * index
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = APB_ADDR_W'(4 * REG_WINDOW);

    // every input is known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_word              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    time_window_spike_fifo dut (.*);

    always #5 i_clk = ~i_clk;

    // idle odds in percent, changed between phases
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    // set by a test to make the receiver hold off; hold_left counts the hold-off down
    int hold_request = 0;
    int hold_left    = 0;

    int mismatches  = 0;
    int idle_cycles = 0;

    // mirror of the fifo state, updated as each word is accepted
    logic [STAMP_W-1:0] mirror_stamp [DEPTH];
    logic [CONN_W-1:0]  mirror_conn  [DEPTH];
    logic [IDX_W-1:0]   mirror_head   = '0;
    logic [IDX_W-1:0]   mirror_tail   = '0;
    int unsigned        mirror_held   = 0;
    logic [STAMP_W-1:0] mirror_now    = '0;
    logic [WIN_W-1:0]   mirror_window = '0;

    // result words still owed by the block, oldest first
    t_out_word due_words [$];
    t_out_word oldest_due;

    // advance the mirror by one command word and return the status word it should produce
    function automatic t_out_word apply_spike_cmd(t_in_word w);
        t_out_word        r;
        logic [IDX_W-1:0] slot;
        r = '0;
        case (w.command)
            CMD_ADD: begin
                if (mirror_held >= DEPTH) begin
                    // full: spike refused, nothing moves
                    r.add_dropped = 1'b1;
                end else begin
                    mirror_stamp[mirror_tail] = mirror_now;
                    mirror_conn[mirror_tail]  = w.connection_id;
                    mirror_tail = mirror_tail + 1'b1;
                    mirror_held++;
                end
            end
            CMD_ADVANCE: begin
                // time wraps mod 2^32, ages stay right through the subtract
                mirror_now = mirror_now + STAMP_W'(w.elapsed_ticks);
                while (mirror_held > 0 &&
                       (mirror_now - mirror_stamp[mirror_head]) > {1'b0, mirror_window}) begin
                    mirror_head = mirror_head + 1'b1;
                    mirror_held--;
                end
            end
            CMD_READ: begin
                // positions past the held entries report zero entry fields
                if (w.position < mirror_held) begin
                    slot               = mirror_head + w.position;
                    r.entry_valid      = 1'b1;
                    r.entry_age        = mirror_now - mirror_stamp[slot];
                    r.entry_connection = mirror_conn[slot];
                end
            end
            default: begin
                // unused code: count only
            end
        endcase
        r.spike_count = SPIKE_COUNT_W'(mirror_held);
        return r;
    endfunction

    function automatic t_in_word cmd_word(logic [1:0] cmd, logic [CONN_W-1:0] conn,
                                          logic [15:0] ticks, logic [POS_W-1:0] pos);
        t_in_word w;
        w.command       = cmd;
        w.connection_id = conn;
        w.elapsed_ticks = ticks;
        w.position      = pos;
        return w;
    endfunction

    // offer one word after a random gap, hold it until taken, then book its result
    task automatic push_word(t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        due_words.push_back(apply_spike_cmd(w));
    endtask

    // drop valid and wait until every owed result word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(negedge i_clk);
    endtask

    // window register write, only with the block idle
    task automatic write_window(logic [APB_DATA_W-1:0] value);
        wait_drained();
        repeat (4) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_window = value[WIN_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // receiver: random ready, or a long hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_request > 0) begin
            i_out_ready  <= 1'b0;
            hold_left    <= hold_request;
            hold_request = 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // result checker: each word taken is compared to the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_words.size() == 0) begin
                $error("result word with nothing owed: %h", o_out_data);
                mismatches++;
            end else begin
                oldest_due = due_words.pop_front();
                check_field("spike_count", 32'(oldest_due.spike_count),
                            32'(o_out_data.spike_count));
                check_field("entry_valid", 32'(oldest_due.entry_valid),
                            32'(o_out_data.entry_valid));
                check_field("entry_age", oldest_due.entry_age, o_out_data.entry_age);
                check_field("entry_connection", 32'(oldest_due.entry_connection),
                            32'(o_out_data.entry_connection));
                check_field("add_dropped", 32'(oldest_due.add_dropped),
                            32'(o_out_data.add_dropped));
            end
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // every command at least once, field extremes, reads past the end, unused code
    task automatic test_basic_commands();
        write_window(32'd10);
        push_word(cmd_word(CMD_READ, 16'hFFFF, 16'hFFFF, 6'd0));
        push_word(cmd_word(CMD_ADD, 16'h0000, 16'hFFFF, 6'd63));
        push_word(cmd_word(CMD_ADD, 16'hFFFF, 16'h0000, 6'd0));
        push_word(cmd_word(CMD_READ, 16'h0000, 16'h0000, 6'd0));
        push_word(cmd_word(CMD_READ, 16'hFFFF, 16'hFFFF, 6'd1));
        push_word(cmd_word(CMD_READ, 16'h0000, 16'h0000, 6'd2));
        push_word(cmd_word(CMD_READ, 16'h0000, 16'h0000, 6'd63));
        push_word(cmd_word(CMD_ADVANCE, 16'hFFFF, 16'd0, 6'd63));
        push_word(cmd_word(CMD_ADVANCE, 16'h0000, 16'd10, 6'd0));
        // age equal to the window stays
        push_word(cmd_word(CMD_READ, 16'h0000, 16'h0000, 6'd1));
        push_word(cmd_word(CMD_ADD, 16'h5A5A, 16'h0000, 6'd0));
        push_word(cmd_word(2'd3, 16'hFFFF, 16'hFFFF, 6'd63));
        push_word(cmd_word(CMD_ADVANCE, 16'h0000, 16'd1, 6'd0));
        push_word(cmd_word(CMD_READ, 16'h0000, 16'h0000, 6'd0));
        push_word(cmd_word(CMD_ADVANCE, 16'h0000, 16'hFFFF, 6'd0));
        push_word(cmd_word(CMD_READ, 16'hFFFF, 16'hFFFF, 6'd0));
        push_word(cmd_word(2'd3, 16'h0000, 16'h0000, 6'd0));
    endtask

    // zero window: only spikes of age zero survive an advance
    task automatic test_window_zero();
        write_window(32'd0);
        push_word(cmd_word(CMD_ADD, 16'h1234, 16'd0, 6'd0));
        push_word(cmd_word(CMD_ADD, 16'h4321, 16'd0, 6'd0));
        push_word(cmd_word(CMD_ADVANCE, 16'd0, 16'd0, 6'd0));
        push_word(cmd_word(CMD_READ, 16'd0, 16'd0, 6'd1));
        push_word(cmd_word(CMD_ADVANCE, 16'd0, 16'd1, 6'd0));
        push_word(cmd_word(CMD_READ, 16'd0, 16'd0, 6'd0));
    endtask

    // fill to the top, refused adds, then a zero window empties all 64 in one advance
    task automatic test_full_and_drop();
        // upper bit of the write is beyond the register and ignored
        write_window(32'hFFFF_FFFF);
        while (mirror_held < DEPTH)
            push_word(cmd_word(CMD_ADD, 16'($urandom_range(0, 65535)), 16'd0, 6'd0));
        push_word(cmd_word(CMD_ADD, 16'hFFFF, 16'd0, 6'd0));
        push_word(cmd_word(CMD_ADD, 16'h0000, 16'd0, 6'd0));
        push_word(cmd_word(CMD_READ, 16'd0, 16'd0, 6'd63));
        push_word(cmd_word(CMD_ADVANCE, 16'd0, 16'hFFFF, 6'd0));
        push_word(cmd_word(CMD_READ, 16'd0, 16'd0, 6'd0));
        push_word(cmd_word(2'd3, 16'd0, 16'd0, 6'd0));
        write_window(32'd0);
        push_word(cmd_word(CMD_ADVANCE, 16'd0, 16'd1, 6'd0));
        push_word(cmd_word(CMD_READ, 16'd0, 16'd0, 6'd0));
    endtask

    // receiver holds off while words keep coming, so the input side must stall
    task automatic test_output_hold();
        int n;
        hold_request = 80;
        for (n = 0; n < 12; n++)
            push_word(cmd_word(2'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 200)), 6'($urandom_range(0, 63))));
        // sender waits for every result before going on
        wait_drained();
    endtask

    // near-maximum advances between spikes, ages of many thousand ticks
    task automatic test_long_advances();
        int n;
        write_window(32'd100000);
        for (n = 0; n < 8; n++) begin
            push_word(cmd_word(CMD_ADD, 16'($urandom_range(0, 65535)), 16'd0, 6'd0));
            push_word(cmd_word(CMD_ADVANCE, 16'd0, 16'(16'hFFFF - $urandom_range(0, 255)),
                               6'd0));
            push_word(cmd_word(CMD_READ, 16'd0, 16'd0,
                               6'($urandom_range(0, mirror_held > 0 ? mirror_held - 1 : 0))));
        end
    endtask

    // random traffic: add bursts, advances near the window and mostly in-range reads,
    // with some unused codes and fully random words mixed in
    task automatic test_random_traffic(int n_words, logic [31:0] window, int ticks_max);
        int          sent;
        int          pick;
        int          burst;
        logic [15:0] ticks;
        logic [5:0]  pos;
        write_window(window);
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                    push_word(cmd_word(CMD_ADD, 16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63))));
                sent += burst;
            end else if (pick < 60) begin
                // a quarter of advances span the whole tick field
                if ($urandom_range(3) == 0)
                    ticks = 16'($urandom_range(0, 65535));
                else
                    ticks = 16'($urandom_range(0, ticks_max));
                push_word(cmd_word(CMD_ADVANCE, 16'($urandom_range(0, 65535)), ticks,
                                   6'($urandom_range(0, 63))));
                sent++;
            end else if (pick < 88) begin
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    if (mirror_held > 0 && $urandom_range(4) != 0)
                        pos = 6'($urandom_range(0, mirror_held - 1));
                    else
                        pos = 6'($urandom_range(0, 63));
                    push_word(cmd_word(CMD_READ, 16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)), pos));
                end
                sent += burst;
            end else if (pick < 93) begin
                // no-op code, not counted
                push_word(cmd_word(2'd3, 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63))));
            end else begin
                push_word(cmd_word(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)), 6'($urandom_range(0, 63))));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: sender gaps light, receiver stalls heavy
        snd_idle_pct = 19;
        rcv_idle_pct = 61;
        test_basic_commands();
        test_window_zero();
        test_full_and_drop();
        test_random_traffic(120, 32'($urandom_range(200, 3000)), 300);

        // phase two: the other way round
        snd_idle_pct = 61;
        rcv_idle_pct = 19;
        test_output_hold();
        test_random_traffic(120, 32'($urandom_range(0, 40)), 12);

        // phase three: no idling on either side
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_output_hold();
        test_long_advances();
        test_random_traffic(130, 32'($urandom_range(1000, 100000)), 20000);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && due_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
